@@ rtl/tkse_pkg.sv @@
package tkse_pkg;

    localparam int LOGIT_W = 24;
    localparam int SUM_W   = 32;
    localparam int BITS_W  = 32;
    localparam int RANK_W  = 6;
    localparam int MW_W    = 7;
    localparam int AV_W    = 6;
    localparam int LC_W    = 6;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] REG_MODELS_WANTED = 1'd0;
    localparam logic [CIDX_W-1:0] REG_ACTIVE_VARS   = 1'd1;

endpackage

@@ rtl/top_k_subset_sum_enumerator_core.sv @@
// Loads active_vars signed Q8.16 logits, already sorted, one beat per cycle, and on the
// last load enumerates the models_wanted best inclusion patterns in falling order of
// summed logits. Loads are taken every cycle while no run is in progress. A run first
// sweeps the logit memory for the root sum, then each model costs one pop of a max-heap
// held in a single synchronous memory plus up to two inserts: every heap level walked is
// a read, then a compare and write back. Loads are refused while a run is in progress;
// the last result beat may still wait on the output while the next loads come in.
module top_k_subset_sum_enumerator_core #(
    parameter int MAX_VARS    = 32,
    parameter int MAX_MODELS  = 64,
    parameter int TABLE_DEPTH = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tkse_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [tkse_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [tkse_pkg::LOGIT_W-1:0] logit,
    input  logic                               flip,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tkse_pkg::BITS_W-1:0]        model_bits,
    output logic signed [tkse_pkg::SUM_W-1:0]  subset_sum,
    output logic [tkse_pkg::RANK_W-1:0]        model_rank,
    output logic                               last_model
);

    localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int NW = $clog2(MAX_VARS + 1);
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int HW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = tkse_pkg::SUM_W;

    localparam logic [4:0] ST_LOAD   = 5'd0;
    localparam logic [4:0] ST_SUM    = 5'd1;
    localparam logic [4:0] ST_EMIT   = 5'd2;
    localparam logic [4:0] ST_EXP1   = 5'd3;
    localparam logic [4:0] ST_EXP2RD = 5'd4;
    localparam logic [4:0] ST_EXP2   = 5'd5;
    localparam logic [4:0] ST_ADD    = 5'd6;
    localparam logic [4:0] ST_UP     = 5'd7;
    localparam logic [4:0] ST_UPCMP  = 5'd8;
    localparam logic [4:0] ST_LOOP   = 5'd9;
    localparam logic [4:0] ST_POPRD  = 5'd10;
    localparam logic [4:0] ST_POPLD  = 5'd11;
    localparam logic [4:0] ST_DN     = 5'd12;
    localparam logic [4:0] ST_DNCMP  = 5'd13;
    localparam logic [4:0] ST_FINRD  = 5'd14;
    localparam logic [4:0] ST_FINLD  = 5'd15;
    localparam logic [4:0] ST_DONE   = 5'd16;

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic [AW-1:0]        pos;
        logic [MAX_VARS-1:0]  mask;
    } elem_t;

    logic [4:0]                     state_reg, state_next, ret_reg, ret_next;
    logic [tkse_pkg::MW_W-1:0]      mw_reg, mw_next, kk_reg, kk_next;
    logic [tkse_pkg::AV_W-1:0]      av_reg, av_next;
    logic [tkse_pkg::LC_W-1:0]      lc_reg, lc_next;
    logic [MAX_VARS-1:0]            flip_reg, flip_next;
    logic [NW-1:0]                  idx_reg, idx_next;
    logic                           rdv_reg, rdv_next;
    logic [AW-1:0]                  rdi_reg, rdi_next;
    logic signed [SW-1:0]           acc_reg, acc_next;
    logic signed [tkse_pkg::LOGIT_W-1:0] llast_reg, llast_next;
    elem_t                          e_reg, e_next, mv_reg, mv_next;
    logic [TW-1:0]                  pos_reg, pos_next;
    logic [HW-1:0]                  hc_reg, hc_next, tc_reg, tc_next;
    logic [tkse_pkg::MW_W-1:0]      cnt_reg, cnt_next;
    logic                           second_reg, second_next;
    logic                           pend_v_reg, pend_v_next;
    logic [tkse_pkg::BITS_W-1:0]    pend_bits_reg, pend_bits_next;
    logic signed [SW-1:0]           pend_sum_reg, pend_sum_next;
    logic [tkse_pkg::RANK_W-1:0]    pend_rank_reg, pend_rank_next;
    logic                           ov_reg, ov_next;
    logic [tkse_pkg::BITS_W-1:0]    obits_reg, obits_next;
    logic signed [SW-1:0]           osum_reg, osum_next;
    logic [tkse_pkg::RANK_W-1:0]    orank_reg, orank_next;
    logic                           olast_reg, olast_next;

    logic signed [tkse_pkg::LOGIT_W-1:0] logit_mem [MAX_VARS];
    logic signed [tkse_pkg::LOGIT_W-1:0] la_q, lb_q;
    logic                           lw_en;
    logic [AW-1:0]                  lra, lrb;

    elem_t                          heap_mem [TABLE_DEPTH];
    elem_t                          ha_q, hb_q, hw_data;
    logic                           hw_en;
    logic [TW-1:0]                  hw_addr, ha_addr, hb_addr;

    logic [NW-1:0]                  n_cur;
    logic [AW-1:0]                  nm1;
    logic [tkse_pkg::MW_W-1:0]      k_eff, k_lim;
    logic [MAX_VARS-1:0]            full_vec, e_bits_v;
    logic                           out_free;
    logic [tkse_pkg::LC_W-1:0]      lc_inc;
    logic [TW+1:0]                  k1, k2, hcx;
    logic [TW-1:0]                  par;
    logic                           has2, move, pick2;

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            logit_mem[lc_reg[AW-1:0]] <= logit;
        end
        la_q <= logit_mem[lra];
        lb_q <= logit_mem[lrb];
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[hw_addr] <= hw_data;
        end
        ha_q <= (hw_en && hw_addr == ha_addr) ? hw_data : heap_mem[ha_addr];
        hb_q <= (hw_en && hw_addr == hb_addr) ? hw_data : heap_mem[hb_addr];
    end

    always_comb
    begin
        if (av_reg == '0)
        begin
            n_cur = NW'(1);
        end
        else if (7'(av_reg) > 7'(MAX_VARS))
        begin
            n_cur = NW'(MAX_VARS);
        end
        else
        begin
            n_cur = NW'(av_reg);
        end
        nm1 = AW'(n_cur - NW'(1));
        if (mw_reg == '0)
        begin
            k_eff = 7'd1;
        end
        else if (mw_reg > 7'(MAX_MODELS))
        begin
            k_eff = 7'(MAX_MODELS);
        end
        else
        begin
            k_eff = mw_reg;
        end
        k_lim = 7'd1 << 7'(n_cur);
        if (7'(n_cur) < 7'd7 && k_eff > k_lim)
        begin
            k_eff = k_lim;
        end
        for (int i = 0; i < MAX_VARS; i++)
        begin
            full_vec[i] = (i < int'(n_cur));
        end
        e_bits_v = (full_vec & ~e_reg.mask) ^ (flip_reg & full_vec);
    end

    assign out_free = !ov_reg || !out_stall;
    assign lc_inc   = lc_reg + tkse_pkg::LC_W'(1);
    assign k1       = {1'b0, pos_reg, 1'b1};
    assign k2       = k1 + (TW+2)'(1);
    assign hcx      = (TW+2)'(hc_reg);
    assign par      = (pos_reg - TW'(1)) >> 1;

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        mw_next = mw_reg;
        av_next = av_reg;
        kk_next = kk_reg;
        lc_next = lc_reg;
        flip_next = flip_reg;
        idx_next = idx_reg;
        rdv_next = rdv_reg;
        rdi_next = rdi_reg;
        acc_next = acc_reg;
        llast_next = llast_reg;
        e_next = e_reg;
        mv_next = mv_reg;
        pos_next = pos_reg;
        hc_next = hc_reg;
        tc_next = tc_reg;
        cnt_next = cnt_reg;
        second_next = second_reg;
        pend_v_next = pend_v_reg;
        pend_bits_next = pend_bits_reg;
        pend_sum_next = pend_sum_reg;
        pend_rank_next = pend_rank_reg;
        ov_next = ov_reg;
        obits_next = obits_reg;
        osum_next = osum_reg;
        orank_next = orank_reg;
        olast_next = olast_reg;
        in_stall = 1'b1;
        lw_en = 1'b0;
        lra = '0;
        lrb = '0;
        hw_en = 1'b0;
        hw_addr = '0;
        hw_data = mv_reg;
        ha_addr = '0;
        hb_addr = '0;
        has2 = 1'b0;
        move = 1'b0;
        pick2 = 1'b0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                tkse_pkg::REG_MODELS_WANTED: mw_next = cfg_data;
                tkse_pkg::REG_ACTIVE_VARS:   av_next = cfg_data[tkse_pkg::AV_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (7'(lc_reg) < 7'(MAX_VARS))
                    begin
                        lw_en = 1'b1;
                        flip_next[lc_reg[AW-1:0]] = flip;
                    end
                    if (7'(lc_inc) >= 7'(n_cur))
                    begin
                        lc_next = '0;
                        idx_next = '0;
                        rdv_next = 1'b0;
                        acc_next = '0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        lc_next = lc_inc;
                    end
                end
            end
            ST_SUM:
            begin
                rdv_next = 1'b0;
                if (idx_reg < n_cur)
                begin
                    lra = idx_reg[AW-1:0];
                    rdv_next = 1'b1;
                    rdi_next = idx_reg[AW-1:0];
                    idx_next = idx_reg + NW'(1);
                end
                if (rdv_reg)
                begin
                    acc_next = acc_reg + SW'(la_q);
                    if (rdi_reg == nm1)
                    begin
                        llast_next = la_q;
                        e_next.sum = acc_reg + SW'(la_q);
                        e_next.pos = '0;
                        e_next.mask = '0;
                        kk_next = k_eff;
                        cnt_next = '0;
                        hc_next = '0;
                        tc_next = HW'(1);
                        rdv_next = 1'b0;
                        ret_next = ST_EXP1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!pend_v_reg || out_free)
                begin
                    if (pend_v_reg)
                    begin
                        ov_next = 1'b1;
                        obits_next = pend_bits_reg;
                        osum_next = pend_sum_reg;
                        orank_next = pend_rank_reg;
                        olast_next = 1'b0;
                    end
                    pend_v_next = 1'b1;
                    pend_bits_next = tkse_pkg::BITS_W'(e_bits_v);
                    pend_sum_next = e_reg.sum;
                    pend_rank_next = tkse_pkg::RANK_W'(cnt_reg);
                    cnt_next = cnt_reg + 7'd1;
                    state_next = ret_reg;
                end
            end
            ST_EXP1:
            begin
                second_next = 1'b0;
                if (!e_reg.mask[nm1])
                begin
                    mv_next.sum = e_reg.sum - SW'(llast_reg);
                    mv_next.pos = nm1;
                    mv_next.mask = e_reg.mask | (MAX_VARS'(1) << nm1);
                    state_next = ST_ADD;
                end
                else
                begin
                    state_next = ST_EXP2RD;
                end
            end
            ST_EXP2RD:
            begin
                if (e_reg.pos != '0 && NW'(e_reg.pos) < n_cur
                    && !e_reg.mask[e_reg.pos - AW'(1)])
                begin
                    lra = e_reg.pos;
                    lrb = e_reg.pos - AW'(1);
                    state_next = ST_EXP2;
                end
                else
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_EXP2:
            begin
                second_next = 1'b1;
                mv_next.sum = e_reg.sum + SW'(la_q) - SW'(lb_q);
                mv_next.pos = e_reg.pos - AW'(1);
                mv_next.mask = (e_reg.mask & ~(MAX_VARS'(1) << e_reg.pos))
                             | (MAX_VARS'(1) << (e_reg.pos - AW'(1)));
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if ((HW+1)'(tc_reg) + (HW+1)'(1) >= (HW+1)'(TABLE_DEPTH)
                    || (HW+1)'(hc_reg) >= (HW+1)'(TABLE_DEPTH))
                begin
                    state_next = second_reg ? ST_LOOP : ST_EXP2RD;
                end
                else
                begin
                    tc_next = tc_reg + HW'(1);
                    pos_next = TW'(hc_reg);
                    hc_next = hc_reg + HW'(1);
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                if (pos_reg == '0)
                begin
                    hw_en = 1'b1;
                    hw_addr = pos_reg;
                    hw_data = mv_reg;
                    state_next = second_reg ? ST_LOOP : ST_EXP2RD;
                end
                else
                begin
                    ha_addr = par;
                    state_next = ST_UPCMP;
                end
            end
            ST_UPCMP:
            begin
                hw_en = 1'b1;
                hw_addr = pos_reg;
                if (mv_reg.sum < ha_q.sum)
                begin
                    hw_data = mv_reg;
                    state_next = second_reg ? ST_LOOP : ST_EXP2RD;
                end
                else
                begin
                    hw_data = ha_q;
                    pos_next = par;
                    state_next = ST_UP;
                end
            end
            ST_LOOP:
            begin
                if (8'(cnt_reg) + 8'd1 < 8'(kk_reg))
                begin
                    state_next = (hc_reg == '0) ? ST_DONE : ST_POPRD;
                end
                else if (kk_reg > 7'd1 && 8'(cnt_reg) + 8'd1 == 8'(kk_reg)
                         && hc_reg != '0)
                begin
                    state_next = ST_FINRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POPRD:
            begin
                ha_addr = '0;
                hb_addr = TW'(hc_reg - HW'(1));
                state_next = ST_POPLD;
            end
            ST_POPLD:
            begin
                e_next = ha_q;
                mv_next = hb_q;
                hc_next = hc_reg - HW'(1);
                pos_next = '0;
                ret_next = ST_DN;
                state_next = ST_EMIT;
            end
            ST_DN:
            begin
                if (k1 >= hcx)
                begin
                    hw_en = 1'b1;
                    hw_addr = pos_reg;
                    hw_data = mv_reg;
                    state_next = ST_EXP1;
                end
                else
                begin
                    ha_addr = k1[TW-1:0];
                    hb_addr = k2[TW-1:0];
                    state_next = ST_DNCMP;
                end
            end
            ST_DNCMP:
            begin
                has2 = k2 < hcx;
                if (!has2)
                begin
                    move = mv_reg.sum < ha_q.sum;
                    pick2 = 1'b0;
                end
                else
                begin
                    move = !(mv_reg.sum > ha_q.sum && mv_reg.sum > hb_q.sum);
                    pick2 = ha_q.sum <= hb_q.sum;
                end
                hw_en = 1'b1;
                hw_addr = pos_reg;
                if (move)
                begin
                    hw_data = pick2 ? hb_q : ha_q;
                    pos_next = pick2 ? k2[TW-1:0] : k1[TW-1:0];
                    state_next = ST_DN;
                end
                else
                begin
                    hw_data = mv_reg;
                    state_next = ST_EXP1;
                end
            end
            ST_FINRD:
            begin
                ha_addr = '0;
                state_next = ST_FINLD;
            end
            ST_FINLD:
            begin
                e_next = ha_q;
                ret_next = ST_DONE;
                state_next = ST_EMIT;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    obits_next = pend_bits_reg;
                    osum_next = pend_sum_reg;
                    orank_next = pend_rank_reg;
                    olast_next = 1'b1;
                    pend_v_next = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            ret_reg <= ST_LOAD;
            mw_reg <= 7'd1;
            av_reg <= 6'd1;
            lc_reg <= '0;
            rdv_reg <= 1'b0;
            hc_reg <= '0;
            tc_reg <= HW'(1);
            cnt_reg <= '0;
            second_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            mw_reg <= mw_next;
            av_reg <= av_next;
            lc_reg <= lc_next;
            rdv_reg <= rdv_next;
            hc_reg <= hc_next;
            tc_reg <= tc_next;
            cnt_reg <= cnt_next;
            second_reg <= second_next;
            pend_v_reg <= pend_v_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kk_reg <= kk_next;
        flip_reg <= flip_next;
        idx_reg <= idx_next;
        rdi_reg <= rdi_next;
        acc_reg <= acc_next;
        llast_reg <= llast_next;
        e_reg <= e_next;
        mv_reg <= mv_next;
        pos_reg <= pos_next;
        pend_bits_reg <= pend_bits_next;
        pend_sum_reg <= pend_sum_next;
        pend_rank_reg <= pend_rank_next;
        obits_reg <= obits_next;
        osum_reg <= osum_next;
        orank_reg <= orank_next;
        olast_reg <= olast_next;
    end

    assign out_valid  = ov_reg;
    assign model_bits = obits_reg;
    assign subset_sum = osum_reg;
    assign model_rank = orank_reg;
    assign last_model = olast_reg;

endmodule

@@ rtl/tkse_checker.sv @@
module tkse_checker #(
    parameter int MAX_MODELS = 64
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [tkse_pkg::BITS_W-1:0]       model_bits,
    input logic signed [tkse_pkg::SUM_W-1:0] subset_sum,
    input logic [tkse_pkg::RANK_W-1:0]       model_rank,
    input logic                              last_model
);

    logic [tkse_pkg::RANK_W-1:0] exp_rank_reg;
    logic                        out_beat;

    assign out_beat = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_rank_reg <= '0;
        end
        else if (out_beat)
        begin
            exp_rank_reg <= last_model ? '0 : model_rank + tkse_pkg::RANK_W'(1);
        end
    end

    // Models of a run come out with consecutive ranks, restarting after the last one.
    a_rank_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> model_rank == exp_rank_reg)
        else $error("model rank out of sequence");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && model_rank == tkse_pkg::RANK_W'(MAX_MODELS - 1) |-> last_model)
        else $error("run longer than the model limit");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(model_bits) && $stable(subset_sum)
            && $stable(model_rank) && $stable(last_model))
        else $error("stalled result beat changed");

endmodule

bind top_k_subset_sum_enumerator_core tkse_checker #(.MAX_MODELS(MAX_MODELS)) u_tkse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .model_bits (model_bits),
    .subset_sum (subset_sum),
    .model_rank (model_rank),
    .last_model (last_model)
);
